[hdl/cmf_pkg.sv]
// Package with the item types and constants of the composite marking filter.
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

   localparam int VALUE_WIDTH = 31;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value_in;
      logic                   is_last;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value_out;
      logic                   last_out;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/composite_marking_filter_core.sv]
// Top level of the composite marking filter: trial division sequencer and ports.
//
//   Channel   Ports                          Handshake
//   request   start, busy, req_data          taken when start is high and busy low
//   response  rsp_strobe, rsp_data           valid for one cycle, cannot be stalled
//   csr       csr_valid, csr_ready, csr_data divisor limit, written on valid and ready
//
// Each trial divisor goes through a check step and then the shared remainder unit.
// An item tries divisors from 2 while the divisor is below the limit and its square
// does not exceed the value, and stops at the first divisor found.
// Reset is synchronous and clears the limit to zero; busy is high until the result
// strobe has been shown.
`timescale 1ns / 1ps
`default_nettype none

module composite_marking_filter_core
   import cmf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [VALUE_WIDTH-1:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] limit_ff, limit_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   last_ff, last_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH:0]   sq_ff, sq_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;
   logic                   rem_start;
   logic                   rem_done;
   logic                   rem_zero;

   cmf_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (value_ff),
      .divisor  (div_ff),
      .done     (rem_done),
      .rem_zero (rem_zero)
   );

   always_comb begin
      state_in  = state_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      div_in    = div_ff;
      sq_in     = sq_ff;
      result_in = result_ff;
      rem_start = 1'b0;
      limit_in  = (csr_valid) ? csr_data : limit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_data.value_in;
               last_in  = req_data.is_last;
               div_in   = VALUE_WIDTH'(2);
               sq_in    = (VALUE_WIDTH + 1)'(4);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (limit_ff <= VALUE_WIDTH'(2) || value_ff == VALUE_WIDTH'(2)) begin
               result_in = value_ff;
               state_in  = ST_REPORT;
            end else if (value_ff == '0) begin
               result_in = VALUE_WIDTH'(1);
               state_in  = ST_REPORT;
            end else if (div_ff < limit_ff && sq_ff <= {1'b0, value_ff}) begin
               rem_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               result_in = value_ff;
               state_in  = ST_REPORT;
            end
         end
         ST_DIVIDE: begin
            if (rem_done) begin
               if (rem_zero) begin
                  result_in = VALUE_WIDTH'(1);
                  state_in  = ST_REPORT;
               end else begin
                  div_in   = div_ff + 1'b1;
                  sq_in    = sq_ff + {div_ff, 1'b1};
                  state_in = ST_CHECK;
               end
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
      end
      value_ff  <= value_in;
      last_ff   <= last_in;
      div_ff    <= div_in;
      sq_ff     <= sq_in;
      result_ff <= result_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_strobe         = (state_ff == ST_REPORT);
   assign rsp_data.value_out = result_ff;
   assign rsp_data.last_out  = last_ff;

endmodule

`default_nettype wire

[hdl/cmf_rem_unit.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cmf_rem_unit
   import cmf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output logic                        done,
   output logic                        rem_zero
);

   logic [VALUE_WIDTH:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   trial;

   always_comb begin
      trial    = {rem_ff[VALUE_WIDTH-1:0], shift_ff[VALUE_WIDTH-1]};
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         shift_in = dividend;
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
         end else begin
            rem_in = trial;
         end
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

`default_nettype wire

[tb/tb_composite_marking_filter_core.sv]
// Self-checking testbench for the composite marking filter core with directed and random items.
`timescale 1ns / 1ps

module tb_composite_marking_filter_core;
   import cmf_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
   localparam int ITEMS_PER_SEGMENT = 27;
   localparam int SEGMENT_COUNT = 10;

   typedef struct {
      logic [VALUE_WIDTH-1:0] limit;
      logic [VALUE_WIDTH-1:0] value;
      logic                   is_last;
      bit                     typed;
      logic [VALUE_WIDTH-1:0] value_want;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [VALUE_WIDTH-1:0] csr_data;

   logic [VALUE_WIDTH-1:0] divisor_limit = '0;
   rsp_type                pending_results[$];
   int unsigned            error_count = 0;

   directed_row_type directed_rows [25] = '{
      '{0,         0,            1'b0, 1'b1, 0},
      '{0,         VALUE_MAX,    1'b1, 1'b1, VALUE_MAX},
      '{2,         0,            1'b0, 1'b1, 0},
      '{2,         4,            1'b1, 1'b1, 4},
      '{3,         0,            1'b0, 1'b1, 1},
      '{3,         1,            1'b0, 1'b1, 1},
      '{3,         2,            1'b1, 1'b1, 2},
      '{3,         4,            1'b0, 1'b1, 1},
      '{3,         9,            1'b0, 1'b0, 0},
      '{3,         31'h7FFFFFFE, 1'b0, 1'b1, 1},
      '{3,         VALUE_MAX,    1'b1, 1'b0, 0},
      '{40,        97,           1'b0, 1'b0, 0},
      '{40,        91,           1'b0, 1'b0, 0},
      '{40,        1369,         1'b0, 1'b0, 0},
      '{40,        1681,         1'b1, 1'b0, 0},
      '{40,        VALUE_MAX,    1'b0, 1'b0, 0},
      '{40,        31'h55555555, 1'b0, 1'b0, 0},
      '{40,        31'h2AAAAAAA, 1'b1, 1'b0, 0},
      '{VALUE_MAX, 0,            1'b0, 1'b1, 1},
      '{VALUE_MAX, 1,            1'b0, 1'b1, 1},
      '{VALUE_MAX, 2,            1'b1, 1'b1, 2},
      '{VALUE_MAX, 3,            1'b0, 1'b0, 0},
      '{VALUE_MAX, 65521,        1'b0, 1'b0, 0},
      '{VALUE_MAX, 31'h7FFFFFFE, 1'b1, 1'b1, 1},
      '{0,         6,            1'b1, 1'b1, 6}
   };

   composite_marking_filter_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type filter_value(input logic [VALUE_WIDTH-1:0] value,
                                            input logic is_last,
                                            input logic [VALUE_WIDTH-1:0] limit);
      longint unsigned v;
      longint unsigned lim;
      longint unsigned j;
      logic            divisible;
      rsp_type         r;
      v = value;
      lim = limit;
      divisible = 1'b0;
      if (lim > 2 && v != 2) begin
         if (v == 0) begin
            divisible = 1'b1;
         end else begin
            j = 2;
            while (!divisible && j < lim && j * j <= v) begin
               if (v % j == 0) begin
                  divisible = 1'b1;
               end
               j++;
            end
         end
      end
      r.value_out = divisible ? VALUE_WIDTH'(1) : value;
      r.last_out = is_last;
      return r;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(20, 100);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value(input bit big_limit);
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (big_limit) begin
         return (sel < 2) ? VALUE_WIDTH'($urandom_range(0, 3))
                          : VALUE_WIDTH'($urandom_range(0, 4095));
      end
      case (sel)
         0, 1, 2, 3: begin
            return VALUE_WIDTH'($urandom);
         end
         4, 5: begin
            return VALUE_WIDTH'($urandom_range(0, 300));
         end
         6: begin
            return VALUE_WIDTH'($urandom_range(2, 60) * $urandom_range(2, 60));
         end
         default: begin
            return VALUE_WIDTH'($urandom_range(0, 3));
         end
      endcase
   endfunction

   task automatic idle(input int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      pending_results.push_back(typed ? want
                                      : filter_value(item.value_in, item.is_last, divisor_limit));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_limit(input logic [VALUE_WIDTH-1:0] lim);
      csr_valid <= 1'b1;
      csr_data <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      divisor_limit = lim;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected item: value_out %0d, last_out %0d",
                   rsp_data.value_out, rsp_data.last_out);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.value_out !== want.value_out) begin
               $error("value_out: expected %0d, got %0d", want.value_out, rsp_data.value_out);
               error_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out: expected %0d, got %0d", want.last_out, rsp_data.last_out);
               error_count++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("composite_marking_filter_core: mismatch");
      $finish;
   end

   initial begin
      req_type                item;
      rsp_type                want;
      logic [VALUE_WIDTH-1:0] lim;
      bit                     big_limit;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].limit != divisor_limit) begin
            drain();
            write_limit(directed_rows[i].limit);
         end
         item.value_in = directed_rows[i].value;
         item.is_last = directed_rows[i].is_last;
         want.value_out = directed_rows[i].value_want;
         want.last_out = directed_rows[i].is_last;
         idle(gap_length());
         send_item(item, directed_rows[i].typed, want);
      end

      // Large limits are paired with small values to keep each item short.
      for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
         drain();
         repeat ($urandom_range(0, 3)) @(posedge clock);
         if (seg == 0) begin
            lim = 1;
         end else if (seg == 1) begin
            lim = VALUE_MAX;
         end else if (seg % 3 == 2) begin
            lim = VALUE_WIDTH'($urandom_range(32'h7FFFFFFF, 32'h40000000));
         end else begin
            lim = VALUE_WIDTH'($urandom_range(3, 40));
         end
         write_limit(lim);
         big_limit = (lim > 40);
         for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
            item.value_in = pick_value(big_limit);
            item.is_last = ($urandom_range(0, 7) == 0);
            if (seg % 4 != 3) begin
               idle(gap_length());
            end
            send_item(item, 1'b0, want);
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("composite_marking_filter_core: match");
      end else begin
         $display("composite_marking_filter_core: mismatch");
      end
      $finish;
   end

endmodule
